// ===== rtl/gvk_pkg.sv =====
// Package: item types, command codes and primitive kinds for vertex kick assembly
package gvk_pkg;

  // Register write commands
  typedef enum logic [3:0] {
    CMD_PRIM   = 4'd0,
    CMD_PRMODE = 4'd1,
    CMD_RGBAQ  = 4'd2,
    CMD_UV     = 4'd3,
    CMD_ST     = 4'd4,
    CMD_FOG    = 4'd5,
    CMD_XYZ2   = 4'd6,
    CMD_XYZ3   = 4'd7,
    CMD_XYZF2  = 4'd8,
    CMD_XYZF3  = 4'd9
  } cmd_e;

  // Primitive kinds from the low PRIM bits
  localparam logic [2:0] KIND_POINT      = 3'd0;
  localparam logic [2:0] KIND_LINE       = 3'd1;
  localparam logic [2:0] KIND_LINE_STRIP = 3'd2;
  localparam logic [2:0] KIND_TRI        = 3'd3;
  localparam logic [2:0] KIND_TRI_STRIP  = 3'd4;
  localparam logic [2:0] KIND_TRI_FAN    = 3'd5;
  localparam logic [2:0] KIND_SPRITE     = 3'd6;
  localparam logic [2:0] KIND_RESERVED   = 3'd7;

  localparam int          FOG_SHIFT = 56;
  localparam logic [63:0] POS_MASK  = 64'h00FF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]  command;
    logic [63:0] data;
  } in_item_t;

  typedef struct packed {
    logic [63:0] vertex_position;
    logic [63:0] vertex_color_q;
    logic [63:0] vertex_uv;
    logic [63:0] vertex_st;
    logic [7:0]  vertex_fog;
    logic [10:0] prim_attributes;
    logic        last_vertex;
  } out_item_t;

  // One stored vertex
  typedef struct packed {
    logic [63:0] position;
    logic [63:0] color_q;
    logic [63:0] uv;
    logic [63:0] st;
    logic [7:0]  fog;
  } vertex_t;

  // One assembled triangle: vtx[0] goes out first, vtx[2] last
  typedef struct packed {
    vertex_t [2:0] vtx;
    logic [10:0]   attr;
  } tri_t;

  // Front to queue write side
  typedef struct packed {
    logic push;
    tri_t triangle;
  } q_wr_t;

endpackage

// ===== rtl/gvk_front.sv =====
// Front end: accepts register writes, keeps vertex slots, assembles triangles
module gvk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gvk_pkg::in_item_t in_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              q_full,
  output gvk_pkg::q_wr_t    q_wr
);
  import gvk_pkg::*;

  vertex_t [2:0] slot_r, slot_nxt, slot_w;
  logic [63:0]   cur_color_q_r, cur_color_q_nxt;
  logic [63:0]   cur_uv_r, cur_uv_nxt;
  logic [63:0]   cur_st_r, cur_st_nxt;
  logic [7:0]    cur_fog_r, cur_fog_nxt;
  logic [10:0]   prim_word_r, prim_word_nxt;
  logic [10:0]   prmode_word_r, prmode_word_nxt;
  logic [2:0]    prim_kind_r, prim_kind_nxt;
  logic [1:0]    vleft_r, vleft_nxt;
  logic          mode_r, mode_nxt;

  logic          accept, is_kick, kick, drawing, fogk, complete;
  logic [1:0]    s, vleft_dec;
  vertex_t       nv;
  cmd_e          cmd;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign cmd       = cmd_e'(in_item.command);

  // Kick decode
  always_comb begin
    is_kick = (cmd == CMD_XYZ2) || (cmd == CMD_XYZ3) ||
              (cmd == CMD_XYZF2) || (cmd == CMD_XYZF3);
    drawing = (cmd == CMD_XYZ2) || (cmd == CMD_XYZF2);
    fogk    = (cmd == CMD_XYZF2) || (cmd == CMD_XYZF3);
    kick    = accept && is_kick && (vleft_r != 2'd0);
    s         = (vleft_r == 2'd0) ? 2'd0 : vleft_r - 2'd1;
    vleft_dec = vleft_r - 2'd1;
    complete  = kick && (vleft_dec == 2'd0);
    nv.position = fogk ? (in_item.data & POS_MASK) : in_item.data;
    nv.fog      = fogk ? in_item.data[FOG_SHIFT +: 8] : cur_fog_r;
    nv.color_q  = cur_color_q_r;
    nv.uv       = cur_uv_r;
    nv.st       = cur_st_r;
  end

  // Next state
  always_comb begin
    slot_w          = slot_r;
    cur_color_q_nxt = cur_color_q_r;
    cur_uv_nxt      = cur_uv_r;
    cur_st_nxt      = cur_st_r;
    cur_fog_nxt     = cur_fog_r;
    prim_word_nxt   = prim_word_r;
    prmode_word_nxt = prmode_word_r;
    prim_kind_nxt   = prim_kind_r;
    vleft_nxt       = vleft_r;
    mode_nxt        = (cfg_valid && cfg_ready) ? cfg_data : mode_r;

    if (accept) begin
      unique case (cmd)
        CMD_PRIM: begin
          prim_word_nxt = in_item.data[10:0];
          prim_kind_nxt = in_item.data[2:0];
          unique case (in_item.data[2:0])
            KIND_POINT: vleft_nxt = 2'd1;
            KIND_LINE, KIND_LINE_STRIP, KIND_SPRITE: vleft_nxt = 2'd2;
            KIND_TRI, KIND_TRI_STRIP, KIND_TRI_FAN: vleft_nxt = 2'd3;
            KIND_RESERVED: vleft_nxt = vleft_r;
          endcase
        end
        CMD_PRMODE: prmode_word_nxt = in_item.data[10:0];
        CMD_RGBAQ:  cur_color_q_nxt = in_item.data;
        CMD_UV:     cur_uv_nxt = in_item.data;
        CMD_ST:     cur_st_nxt = in_item.data;
        CMD_FOG:    cur_fog_nxt = in_item.data[FOG_SHIFT +: 8];
        default: ;
      endcase
    end

    if (kick) begin
      slot_w[s] = nv;
      vleft_nxt = vleft_dec;
    end

    // Set completion: restart count and shift slots
    slot_nxt = slot_w;
    if (complete) begin
      unique case (prim_kind_r)
        KIND_POINT:  vleft_nxt = 2'd1;
        KIND_LINE:   vleft_nxt = 2'd2;
        KIND_LINE_STRIP: begin
          slot_nxt[1] = slot_w[0];
          vleft_nxt   = 2'd1;
        end
        KIND_TRI:    vleft_nxt = 2'd3;
        KIND_TRI_STRIP: begin
          slot_nxt[2] = slot_w[1];
          slot_nxt[1] = slot_w[0];
          vleft_nxt   = 2'd1;
        end
        KIND_TRI_FAN: begin
          slot_nxt[1] = slot_w[0];
          vleft_nxt   = 2'd1;
        end
        KIND_SPRITE: vleft_nxt = 2'd2;
        KIND_RESERVED: vleft_nxt = 2'd0;
      endcase
    end
  end

  // Triangle to the queue, oldest vertex first
  always_comb begin
    q_wr.push = complete && drawing &&
                ((prim_kind_r == KIND_TRI) || (prim_kind_r == KIND_TRI_STRIP) ||
                 (prim_kind_r == KIND_TRI_FAN));
    q_wr.triangle.vtx[0] = slot_w[2];
    q_wr.triangle.vtx[1] = slot_w[1];
    q_wr.triangle.vtx[2] = slot_w[0];
    q_wr.triangle.attr   = mode_r ? prim_word_r : prmode_word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r        <= '0;
      cur_color_q_r <= '0;
      cur_uv_r      <= '0;
      cur_st_r      <= '0;
      cur_fog_r     <= '0;
      prim_word_r   <= '0;
      prmode_word_r <= '0;
      prim_kind_r   <= KIND_POINT;
      vleft_r       <= '0;
      mode_r        <= 1'b1;
    end else begin
      slot_r        <= slot_nxt;
      cur_color_q_r <= cur_color_q_nxt;
      cur_uv_r      <= cur_uv_nxt;
      cur_st_r      <= cur_st_nxt;
      cur_fog_r     <= cur_fog_nxt;
      prim_word_r   <= prim_word_nxt;
      prmode_word_r <= prmode_word_nxt;
      prim_kind_r   <= prim_kind_nxt;
      vleft_r       <= vleft_nxt;
      mode_r        <= mode_nxt;
    end
  end

endmodule

// ===== rtl/gvk_queue.sv =====
// Two-entry triangle queue between front and back
module gvk_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  gvk_pkg::q_wr_t q_wr,
  output logic           q_full,
  output logic           q_valid,
  output gvk_pkg::tri_t  q_head,
  input  logic           q_pop
);
  import gvk_pkg::*;

  tri_t [1:0] ent_r, ent_nxt;
  logic       wr_idx;
  logic [1:0] count_r, count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_head  = ent_r[0];

  // Entry 0 is the head; a pop moves entry 1 forward, a push fills the first free entry
  always_comb begin
    ent_nxt   = ent_r;
    wr_idx    = count_r[0] && !q_pop;
    count_nxt = count_r + {1'b0, q_wr.push} - {1'b0, q_pop};
    if (q_pop) begin
      ent_nxt[0] = ent_r[1];
    end
    if (q_wr.push) begin
      ent_nxt[wr_idx] = q_wr.triangle;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_wr.push) else $error("push into full triangle queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !q_pop) else $error("pop from empty triangle queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

endmodule

// ===== rtl/gvk_back.sv =====
// Back end: sends each queued triangle out as three vertex items
module gvk_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  gvk_pkg::tri_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output gvk_pkg::out_item_t out_item
);
  import gvk_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  vertex_t    v;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Load a queued vertex whenever the output is empty or taken
  always_comb begin
    load  = q_valid && (!out_valid_r || !out_stall);
    q_pop = load && (idx_r == 2'd2);
    unique case (idx_r)
      2'd0:    v = q_head.vtx[0];
      2'd1:    v = q_head.vtx[1];
      default: v = q_head.vtx[2];
    endcase
    out_nxt.vertex_position = v.position;
    out_nxt.vertex_color_q  = v.color_q;
    out_nxt.vertex_uv       = v.uv;
    out_nxt.vertex_st       = v.st;
    out_nxt.vertex_fog      = v.fog;
    out_nxt.prim_attributes = q_head.attr;
    out_nxt.last_vertex     = (idx_r == 2'd2);
    out_valid_nxt = load || (out_valid_r && out_stall);
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd3) else $error("vertex index out of range");
  a_last_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && out_r.last_vertex))
    else $error("triangle popped without its last vertex shown");
  a_idx_moves_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(idx_r)) else $error("vertex index moved without a load");

endmodule

// ===== rtl/gs_vertex_kick_primitive_assembly.sv =====
// Top level: vertex kick and triangle strip/fan/list assembly
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | in_item (command, data)
//  out_    | output    | out_valid/stall  | out_item (vertex fields, attributes, last)
//  cfg_    | input     | cfg_valid/ready  | cfg_data (mode_from_prim)
//
// One register write is taken per cycle unless stalled; state updates in that cycle.
// Each drawn triangle goes through a two-entry queue and leaves as three items,
// one per cycle while out_stall is low.
// in_stall rises only while the triangle queue is full.
// Reset is synchronous, active low; all vertex slots and attributes clear to zero.
module gs_vertex_kick_primitive_assembly (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gvk_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output gvk_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import gvk_pkg::*;

  q_wr_t q_wr;
  tri_t  q_head;
  logic  q_full, q_valid, q_pop;

  gvk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  gvk_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  gvk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== tb/gs_vertex_kick_primitive_assembly_tb.sv =====
// Testbench: vertex kick and triangle assembly checked against a cycle-free predictor
`timescale 1ns / 100ps

module gs_vertex_kick_primitive_assembly_tb;
  import gvk_pkg::*;

  // Command codes the block does not decode
  localparam logic [3:0] CMD_UNUSED_LOW  = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HIGH = 4'd15;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  gs_vertex_kick_primitive_assembly dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Predictor state
  vertex_t     slot_m [3];
  logic [63:0] color_q_m, uv_m, st_m, fog_word_m;
  logic [10:0] prim_bits_m, prmode_bits_m;
  logic [2:0]  kind_m;
  logic [1:0]  left_m;
  logic        mode_from_prim_m;
  out_item_t   vertex_expect_q [$];

  int unsigned error_count = 0;
  int unsigned items_taken = 0;
  int unsigned vertices_seen = 0;
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 46;
  int          hold_off_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Apply one register write to the predictor; returns 0 when the block ignores it
  function automatic bit assemble_vertices(input logic [3:0] cmd, input logic [63:0] d);
    logic [1:0]  s;
    logic [10:0] attr;
    bit          drawing;
    bit          fog_kick;
    out_item_t   o;
    case (cmd)
      CMD_PRIM: begin
        prim_bits_m = d[10:0];
        kind_m = d[2:0];
        case (kind_m)
          KIND_POINT: left_m = 2'd1;
          KIND_LINE, KIND_LINE_STRIP, KIND_SPRITE: left_m = 2'd2;
          KIND_TRI, KIND_TRI_STRIP, KIND_TRI_FAN: left_m = 2'd3;
          default: ; // reserved kind keeps the count
        endcase
        return 1'b1;
      end
      CMD_PRMODE: begin prmode_bits_m = d[10:0]; return 1'b1; end
      CMD_RGBAQ:  begin color_q_m = d; return 1'b1; end
      CMD_UV:     begin uv_m = d; return 1'b1; end
      CMD_ST:     begin st_m = d; return 1'b1; end
      CMD_FOG:    begin fog_word_m = d; return 1'b1; end
      CMD_XYZ2, CMD_XYZ3, CMD_XYZF2, CMD_XYZF3: ;
      default: return 1'b0;
    endcase

    if (left_m == 2'd0) return 1'b0;

    drawing  = (cmd == CMD_XYZ2) || (cmd == CMD_XYZF2);
    fog_kick = (cmd == CMD_XYZF2) || (cmd == CMD_XYZF3);
    s = left_m - 2'd1;

    // Latch position plus current attributes; slot 0 is the newest
    if (fog_kick) begin
      slot_m[s].position = d & POS_MASK;
      slot_m[s].fog = 8'(d >> FOG_SHIFT);
    end else begin
      slot_m[s].position = d;
      slot_m[s].fog = 8'(fog_word_m >> FOG_SHIFT);
    end
    slot_m[s].color_q = color_q_m;
    slot_m[s].uv = uv_m;
    slot_m[s].st = st_m;

    left_m = left_m - 2'd1;
    if (left_m != 2'd0) return 1'b1;

    attr = mode_from_prim_m ? prim_bits_m : prmode_bits_m;
    case (kind_m)
      KIND_POINT: left_m = 2'd1;
      KIND_LINE, KIND_SPRITE: left_m = 2'd2;
      KIND_LINE_STRIP: begin
        slot_m[1] = slot_m[0];
        left_m = 2'd1;
      end
      KIND_TRI, KIND_TRI_STRIP, KIND_TRI_FAN: begin
        // oldest vertex first, newest last
        if (drawing) begin
          for (int k = 2; k >= 0; k--) begin
            o.vertex_position = slot_m[k].position;
            o.vertex_color_q  = slot_m[k].color_q;
            o.vertex_uv       = slot_m[k].uv;
            o.vertex_st       = slot_m[k].st;
            o.vertex_fog      = slot_m[k].fog;
            o.prim_attributes = attr;
            o.last_vertex     = (k == 0);
            vertex_expect_q = {vertex_expect_q, o};
          end
        end
        if (kind_m == KIND_TRI) begin
          left_m = 2'd3;
        end else if (kind_m == KIND_TRI_STRIP) begin
          slot_m[2] = slot_m[1];
          slot_m[1] = slot_m[0];
          left_m = 2'd1;
        end else begin
          slot_m[1] = slot_m[0];
          left_m = 2'd1;
        end
      end
      default: ; // reserved kind: no slot change, nothing left
    endcase
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t vertex %0d: %s got %h want %h", $time, vertices_seen, what, got, want);
    error_count++;
  endtask

  task automatic check_vertex(input out_item_t got);
    out_item_t want;
    if (vertex_expect_q.size() == 0) begin
      report_mismatch("unexpected vertex", got.vertex_position, '0);
    end else begin
      want = vertex_expect_q.pop_front();
      if (got.vertex_position !== want.vertex_position)
        report_mismatch("position", got.vertex_position, want.vertex_position);
      if (got.vertex_color_q !== want.vertex_color_q)
        report_mismatch("color_q", got.vertex_color_q, want.vertex_color_q);
      if (got.vertex_uv !== want.vertex_uv)
        report_mismatch("uv", got.vertex_uv, want.vertex_uv);
      if (got.vertex_st !== want.vertex_st)
        report_mismatch("st", got.vertex_st, want.vertex_st);
      if (got.vertex_fog !== want.vertex_fog)
        report_mismatch("fog", 64'(got.vertex_fog), 64'(want.vertex_fog));
      if (got.prim_attributes !== want.prim_attributes)
        report_mismatch("prim_attributes", 64'(got.prim_attributes),
                        64'(want.prim_attributes));
      if (got.last_vertex !== want.last_vertex)
        report_mismatch("last_vertex", 64'(got.last_vertex), 64'(want.last_vertex));
    end
    vertices_seen++;
  endtask

  // Outputs are stable mid-cycle; a vertex seen here is taken at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) check_vertex(out_item);
  end

  // Receiver: random stall, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one item, with random idle cycles first; returns after it is taken
  task automatic send_item(input logic [3:0] cmd, input logic [63:0] d);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.command = cmd;
    it.data = d;
    in_valid <= 1'b1;
    in_item <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (assemble_vertices(cmd, d)) items_taken++;
  endtask

  // Stop offering, wait for every predicted vertex, then let the pipe go quiet
  task automatic settle_vertices();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (vertex_expect_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (vertex_expect_q.size() != 0) begin
      report_mismatch("vertices never emitted", 64'(vertex_expect_q.size()), '0);
      vertex_expect_q.delete();
    end
  endtask

  task automatic write_mode(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    mode_from_prim_m = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Kick with nothing left after reset, and undecoded commands
  task automatic test_idle_kick_and_unused();
    send_item(CMD_XYZ2, ALL_ONES);
    send_item(CMD_UNUSED_HIGH, ALL_ONES);
    send_item(CMD_UNUSED_LOW, rand64());
  endtask

  // An independent triangle with all-ones attributes and both kick flavors
  task automatic test_triangle_list();
    send_item(CMD_RGBAQ, ALL_ONES);
    send_item(CMD_UV, ALL_ONES);
    send_item(CMD_ST, ALL_ONES);
    send_item(CMD_FOG, ALL_ONES);
    send_item(CMD_PRIM, {ALL_ONES[63:3], KIND_TRI});
    send_item(CMD_XYZF2, ALL_ONES);
    send_item(CMD_XYZ2, '0);
    send_item(CMD_XYZ2, ALL_ONES);
  endtask

  // Attribute bits come from PRMODE and are taken when the set completes
  task automatic test_prmode_sampling();
    settle_vertices();
    write_mode(1'b0);
    send_item(CMD_PRIM, {61'(rand64()), KIND_TRI});
    send_item(CMD_XYZ2, rand64());
    send_item(CMD_XYZ2, rand64());
    send_item(CMD_PRMODE, ALL_ONES);
    send_item(CMD_XYZ2, rand64());
    settle_vertices();
    write_mode(1'b1);
  endtask

  // Reserved kind keeps the count, completes silently, then kicks are dropped
  task automatic test_reserved_kind();
    send_item(CMD_PRIM, {61'(rand64()), KIND_RESERVED});
    repeat (3) send_item(CMD_XYZ2, rand64());
    send_item(CMD_XYZF2, rand64());
  endtask

  // Strip with non-drawing kicks that still shift the slots
  task automatic test_strip();
    send_item(CMD_PRIM, {61'(rand64()), KIND_TRI_STRIP});
    send_item(CMD_XYZ2, rand64());
    send_item(CMD_XYZ3, rand64());
    send_item(CMD_XYZ2, rand64());
    send_item(CMD_XYZF3, rand64());
    send_item(CMD_XYZF2, rand64());
  endtask

  // Point and line strip complete sets without output
  task automatic test_point_and_line_strip();
    send_item(CMD_PRIM, {61'(rand64()), KIND_POINT});
    send_item(CMD_XYZ2, rand64());
    send_item(CMD_PRIM, {61'(rand64()), KIND_LINE_STRIP});
    repeat (3) send_item(CMD_XYZF2, rand64());
  endtask

  // Long receiver hold-off while a strip keeps kicking, so the input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 90;
    send_item(CMD_PRIM, {61'(rand64()), KIND_TRI_STRIP});
    repeat (16) send_item(CMD_XYZ2, rand64());
    settle_vertices();
  endtask

  // Mostly well-formed primitive sequences with random content, some noise
  task automatic test_random_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                                   input int unsigned n_items);
    int unsigned goal;
    int unsigned r;
    logic [63:0] d;
    logic [3:0]  cmd;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    goal = items_taken + n_items;
    while (items_taken < goal) begin
      if ($urandom_range(99) < 12) begin
        send_item(4'($urandom_range(15)), rand64());
      end else begin
        d = rand64();
        if ($urandom_range(99) < 80)
          d[2:0] = 3'($urandom_range(KIND_TRI_FAN, KIND_TRI));
        send_item(CMD_PRIM, d);
        repeat ($urandom_range(9, 2)) begin
          r = $urandom_range(99);
          if (r < 25)
            cmd = 4'($urandom_range(CMD_FOG, CMD_PRMODE));
          else if (r < 88)
            cmd = $urandom_range(1) ? CMD_XYZF2 : CMD_XYZ2;
          else
            cmd = $urandom_range(1) ? CMD_XYZF3 : CMD_XYZ3;
          send_item(cmd, rand64());
        end
      end
    end
    settle_vertices();
  endtask

  initial begin
    // predictor reset
    foreach (slot_m[i]) slot_m[i] = '0;
    color_q_m = '0;
    uv_m = '0;
    st_m = '0;
    fog_word_m = '0;
    prim_bits_m = '0;
    prmode_bits_m = '0;
    kind_m = '0;
    left_m = '0;
    mode_from_prim_m = 1'b1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_kick_and_unused();
    test_triangle_list();
    test_prmode_sampling();
    test_reserved_kind();
    test_strip();
    test_point_and_line_strip();
    test_backpressure();

    write_mode(1'b1);
    test_random_phase(8, 46, 27);
    write_mode(1'b0);
    test_random_phase(46, 8, 27);
    write_mode(1'b1);
    test_random_phase(0, 0, 24);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gvk_pkg.sv
rtl/gvk_front.sv
rtl/gvk_queue.sv
rtl/gvk_back.sv
rtl/gs_vertex_kick_primitive_assembly.sv
tb/gs_vertex_kick_primitive_assembly_tb.sv
